// ===== sv/hitt_pkg.sv =====
// Shared types, widths and codes for the heap-indexed tree traversal block.
`default_nettype none

package hitt_pkg;

  localparam int unsigned NODES_DEF      = 63;
  localparam int unsigned LABEL_BITS_DEF = 64;
  localparam int unsigned TREE_DEPTH_DEF = 6;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ORDER_W = 2;
  localparam int unsigned LABEL_W = 64;

  // Slave word: parent_index, side, label, order from the lowest bit up.
  localparam int unsigned S_PARENT_LO = 0;
  localparam int unsigned S_SIDE_LO   = S_PARENT_LO + IDX_W;
  localparam int unsigned S_LABEL_LO  = S_SIDE_LO + 1;
  localparam int unsigned S_ORDER_LO  = S_LABEL_LO + LABEL_W;
  localparam int unsigned S_USED_W    = S_ORDER_LO + ORDER_W;
  localparam int unsigned S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

  // Master word: node_label, node_index from the lowest bit up.
  localparam int unsigned M_INDEX_LO = LABEL_W;
  localparam int unsigned M_USED_W   = M_INDEX_LO + IDX_W;
  localparam int unsigned M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ROOT  = 2'd0,
    FUNC_CHILD = 2'd1,
    FUNC_TRAV  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [ORDER_W-1:0] {
    ORD_PRE  = 2'd0,
    ORD_IN   = 2'd1,
    ORD_POST = 2'd2,
    ORD_NONE = 2'd3
  } order_e;

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_DOWN       = 6'b000010,
    ST_LEFT_DONE  = 6'b000100,
    ST_RIGHT_DONE = 6'b001000,
    ST_FLUSH      = 6'b010000,
    ST_EMPTY      = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ===== sv/hitt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module hitt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/heap_indexed_tree_traversal.sv =====
// Top level of the heap-indexed binary tree store with ordered traversal.
//
// Items arrive on the slave stream; tuser carries the function code (write
// root, write child or traverse). A write gives no word.
// A traverse walks the valid nodes from the root in preorder, inorder or
// postorder and sends one master word per visited node, the final one with
// tlast high. An empty tree gives a single word with tuser high, tlast high
// and index zero. Labels live in a synchronous RAM; valid bits are flops.
// The walker takes one step a cycle while no word it must send is held up
// and needs up to three steps per node (arriving, after the left subtree,
// after the right subtree). A word is released only once the next label
// has been read or the walk has ended, so the first word waits for the
// second label or the end of the walk and comes later in inorder or
// postorder than in preorder. Writes and walks never overlap, as no item
// is taken while a walk is in progress. Reset clears every valid bit, so
// the tree starts empty. A stalled master side holds the output word, and
// the walker halts once its read and pending labels wait behind it.
`default_nettype none

module heap_indexed_tree_traversal #(
  parameter int unsigned NODES      = hitt_pkg::NODES_DEF,
  parameter int unsigned LABEL_BITS = hitt_pkg::LABEL_BITS_DEF,
  parameter int unsigned TREE_DEPTH = hitt_pkg::TREE_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // parent_index, side, label, order from the lowest bit up
  input  wire logic [hitt_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // func
  input  wire logic [hitt_pkg::FUNC_W-1:0]    s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // node_label, node_index from the lowest bit up
  output logic [hitt_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  // empty_res
  output logic                                m_axis_tuser_o
);

  localparam int unsigned IW      = hitt_pkg::IDX_W;
  localparam int unsigned DEPTH_C = (1 << TREE_DEPTH) - 1;
  localparam int unsigned CAP     = (NODES < DEPTH_C) ? NODES : DEPTH_C;
  localparam int unsigned AW      = $clog2(CAP + 1);

  hitt_pkg::state_e            state_q, state_d;
  logic [IW-1:0]               k_q, k_d;
  hitt_pkg::order_e            order_q, order_d;
  logic [CAP:0]                valid_q;
  logic                        rd_vld_q;
  logic [IW-1:0]               rd_idx_q;
  logic                        p_vld_q;
  logic [LABEL_BITS-1:0]       p_label_q;
  logic [IW-1:0]               p_idx_q;
  logic                        o_vld_q;
  logic [LABEL_BITS-1:0]       o_label_q;
  logic [IW-1:0]               o_idx_q;
  logic                        o_last_q;
  logic                        o_empty_q;

  hitt_pkg::func_e             in_func;
  hitt_pkg::order_e            in_order;
  logic [IW-1:0]               in_parent;
  logic                        in_side;
  logic [LABEL_BITS-1:0]       in_label;
  logic                        in_acc;
  logic [IW:0]                 child;
  logic                        child_ok;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [IW:0]                 c_left, c_right;
  logic                        live_left, live_right, live_root;
  logic                        out_free, rd_take, flush_last, empty_go;
  logic                        emit, emit_ok, step;
  logic [LABEL_BITS-1:0]       ram_rdata;

  assign in_func   = hitt_pkg::func_e'(s_axis_tuser_i);
  assign in_parent = s_axis_tdata_i[hitt_pkg::S_PARENT_LO +: IW];
  assign in_side   = s_axis_tdata_i[hitt_pkg::S_SIDE_LO];
  assign in_label  = s_axis_tdata_i[hitt_pkg::S_LABEL_LO +: LABEL_BITS];
  assign in_order  = hitt_pkg::order_e'(s_axis_tdata_i[hitt_pkg::S_ORDER_LO +:
                                                        hitt_pkg::ORDER_W]);

  assign s_axis_tready_o = (state_q == hitt_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign child    = {in_parent, in_side};
  assign child_ok = (in_parent != '0) && (child <= (IW + 1)'(CAP));
  assign wr_en    = in_acc && ((in_func == hitt_pkg::FUNC_ROOT) ||
                               ((in_func == hitt_pkg::FUNC_CHILD) && child_ok));
  assign wr_addr  = (in_func == hitt_pkg::FUNC_ROOT) ? AW'(1) : child[AW-1:0];

  assign c_left     = {k_q, 1'b0};
  assign c_right    = {k_q, 1'b1};
  assign live_left  = (c_left <= (IW + 1)'(CAP)) && valid_q[c_left[AW-1:0]];
  assign live_right = (c_right <= (IW + 1)'(CAP)) && valid_q[c_right[AW-1:0]];
  assign live_root  = valid_q[1];

  assign out_free   = !o_vld_q || m_axis_tready_i;
  assign rd_take    = rd_vld_q && (!p_vld_q || out_free);
  assign flush_last = (state_q == hitt_pkg::ST_FLUSH) && !rd_vld_q && p_vld_q &&
                      out_free;
  assign empty_go   = (state_q == hitt_pkg::ST_EMPTY) && out_free;
  assign emit_ok    = !rd_vld_q || rd_take;

  always_comb begin
    case (state_q)
      hitt_pkg::ST_DOWN:       emit = (order_q == hitt_pkg::ORD_PRE);
      hitt_pkg::ST_LEFT_DONE:  emit = (order_q == hitt_pkg::ORD_IN);
      hitt_pkg::ST_RIGHT_DONE: emit = (order_q == hitt_pkg::ORD_POST);
      default:                 emit = 1'b0;
    endcase
  end

  assign step = !emit || emit_ok;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    order_d = order_q;
    case (state_q)
      hitt_pkg::ST_IDLE: begin
        if (in_acc && (in_func == hitt_pkg::FUNC_TRAV) &&
            (in_order != hitt_pkg::ORD_NONE)) begin
          order_d = in_order;
          k_d     = IW'(1);
          state_d = live_root ? hitt_pkg::ST_DOWN : hitt_pkg::ST_EMPTY;
        end
      end
      hitt_pkg::ST_DOWN: begin
        if (step) begin
          if (live_left) begin
            k_d = c_left[IW-1:0];
          end else begin
            state_d = hitt_pkg::ST_LEFT_DONE;
          end
        end
      end
      hitt_pkg::ST_LEFT_DONE: begin
        if (step) begin
          if (live_right) begin
            k_d     = c_right[IW-1:0];
            state_d = hitt_pkg::ST_DOWN;
          end else begin
            state_d = hitt_pkg::ST_RIGHT_DONE;
          end
        end
      end
      hitt_pkg::ST_RIGHT_DONE: begin
        if (step) begin
          if (k_q == IW'(1)) begin
            state_d = hitt_pkg::ST_FLUSH;
          end else begin
            k_d     = k_q >> 1;
            state_d = k_q[0] ? hitt_pkg::ST_RIGHT_DONE : hitt_pkg::ST_LEFT_DONE;
          end
        end
      end
      hitt_pkg::ST_FLUSH: begin
        if (flush_last) begin
          state_d = hitt_pkg::ST_IDLE;
        end
      end
      hitt_pkg::ST_EMPTY: begin
        if (empty_go) begin
          state_d = hitt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hitt_pkg::ST_IDLE;
      end
    endcase
  end

  hitt_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (CAP + 1)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_label),
    .re_i    (emit && emit_ok),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hitt_pkg::ST_IDLE;
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      p_vld_q  <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (emit && emit_ok) begin
        rd_vld_q <= 1'b1;
      end else if (rd_take) begin
        rd_vld_q <= 1'b0;
      end
      if (rd_take) begin
        p_vld_q <= 1'b1;
      end else if (flush_last) begin
        p_vld_q <= 1'b0;
      end
      if ((rd_take && p_vld_q) || flush_last || empty_go) begin
        o_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    order_q <= order_d;
    if (emit && emit_ok) begin
      rd_idx_q <= k_q;
    end
    if (rd_take) begin
      p_label_q <= ram_rdata;
      p_idx_q   <= rd_idx_q;
    end
    if ((rd_take && p_vld_q) || flush_last) begin
      o_label_q <= p_label_q;
      o_idx_q   <= p_idx_q;
      o_last_q  <= flush_last;
      o_empty_q <= 1'b0;
    end else if (empty_go) begin
      o_label_q <= '0;
      o_idx_q   <= '0;
      o_last_q  <= 1'b1;
      o_empty_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = o_vld_q;
  assign m_axis_tdata_o  = {(hitt_pkg::M_TDATA_W - hitt_pkg::M_USED_W)'(0), o_idx_q,
                            hitt_pkg::LABEL_W'(o_label_q)};
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tuser_o  = o_empty_q;

endmodule

`default_nettype wire

// ===== sv/hitt_checker.sv =====
// Port-level checker for the tree traversal block, bound to the top level.
`default_nettype none

module hitt_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic [hitt_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input wire logic [hitt_pkg::FUNC_W-1:0]    s_axis_tuser_i,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [hitt_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                           m_axis_tlast_o,
  input wire logic                           m_axis_tuser_o
);

  // A waiting slave word must stay on the bus unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s_axis_tvalid_i && !s_axis_tready_o) |->
      (s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tuser_i)))
    else $error("waiting slave word changed");

  // A stalled word must stay on the bus unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(m_axis_tvalid_o && !m_axis_tready_i) |->
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled master word changed");

  // An empty-tree word is a lone final word at index zero.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tlast_o &&
       (m_axis_tdata_o[hitt_pkg::M_INDEX_LO +: hitt_pkg::IDX_W] == '0)))
    else $error("empty word malformed");

  // A visited node never has index zero.
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (m_axis_tdata_o[hitt_pkg::M_INDEX_LO +: hitt_pkg::IDX_W] != '0))
    else $error("visited node at index zero");

  // No item is taken while a walk still has words to deliver.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> !s_axis_tready_o)
    else $error("item taken during a walk");

endmodule

bind heap_indexed_tree_traversal hitt_checker u_hitt_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the heap-indexed tree store with ordered walks.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hitt_pkg::*;

  localparam int unsigned DEPTH_CAP  = (1 << TREE_DEPTH_DEF) - 1;
  localparam int unsigned CAPACITY   = (NODES_DEF < DEPTH_CAP) ? NODES_DEF : DEPTH_CAP;
  localparam logic [LABEL_W-1:0] LABEL_MASK = {LABEL_W{1'b1}} >> (LABEL_W - LABEL_BITS_DEF);
  localparam int unsigned ITEM_TOTAL = 330;
  localparam int unsigned MAX_REPORTS = 40;

  class tree_scoreboard;
    typedef struct {
      logic [LABEL_W-1:0] label;
      logic [IDX_W-1:0]   index;
      logic               last;
      logic               empty;
    } visit_t;

    logic [LABEL_W-1:0] labels [64];
    bit                 live [64];
    visit_t             pending_visits [$];
    int unsigned        walk_path [$];
    int unsigned        errors;

    function new();
      foreach (live[k]) live[k] = 1'b0;
      errors = 0;
    endfunction

    function bit is_live(int unsigned k);
      return k >= 1 && k <= CAPACITY && k < 64 && live[k];
    endfunction

    function void walk_from(int unsigned k, order_e ord);
      if (!is_live(k)) return;
      if (ord == ORD_PRE) walk_path.push_back(k);
      walk_from(2 * k, ord);
      if (ord == ORD_IN) walk_path.push_back(k);
      walk_from(2 * k + 1, ord);
      if (ord == ORD_POST) walk_path.push_back(k);
    endfunction

    function void note_item(func_e func, logic [IDX_W-1:0] parent, logic side,
                            logic [LABEL_W-1:0] label, order_e ord);
      visit_t v;
      int unsigned child;
      case (func)
        FUNC_ROOT: begin
          labels[1] = label & LABEL_MASK;
          live[1]   = 1'b1;
        end
        FUNC_CHILD: begin
          child = 2 * parent + side;
          if (parent != 0 && child <= CAPACITY && child < 64) begin
            labels[child] = label & LABEL_MASK;
            live[child]   = 1'b1;
          end
        end
        FUNC_TRAV: begin
          if (ord != ORD_NONE) begin
            if (!is_live(1)) begin
              v.label = '0;
              v.index = '0;
              v.last  = 1'b1;
              v.empty = 1'b1;
              pending_visits.push_back(v);
            end else begin
              walk_path.delete();
              walk_from(1, ord);
              foreach (walk_path[i]) begin
                v.label = labels[walk_path[i]];
                v.index = walk_path[i][IDX_W-1:0];
                v.last  = (i == walk_path.size() - 1);
                v.empty = 1'b0;
                pending_visits.push_back(v);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string field, logic [LABEL_W-1:0] want, logic [LABEL_W-1:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
    endfunction

    function void check_word(logic [LABEL_W-1:0] label, logic [IDX_W-1:0] index,
                             logic last, logic empty);
      visit_t v;
      if (pending_visits.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("word with no expectation: label %0h index %0d", label, index);
        return;
      end
      v = pending_visits.pop_front();
      if (label !== v.label) report("node_label", v.label, label);
      if (index !== v.index) report("node_index", LABEL_W'(v.index), LABEL_W'(index));
      if (last !== v.last) report("last", LABEL_W'(v.last), LABEL_W'(last));
      if (empty !== v.empty) report("empty_res", LABEL_W'(v.empty), LABEL_W'(empty));
    endfunction
  endclass

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [FUNC_W-1:0]    s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;

  tree_scoreboard sb = new();

  heap_indexed_tree_traversal uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready)
      sb.check_word(m_tdata[0 +: LABEL_W], m_tdata[M_INDEX_LO +: IDX_W], m_tlast, m_tuser);
  end

  initial begin
    int mode;
    int span;
    int unsigned phase;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (phase % 3 != 2);
        endcase
        phase++;
      end
    end
  end

  task automatic send_item(input func_e func, input logic [IDX_W-1:0] parent,
                           input logic side, input logic [LABEL_W-1:0] label,
                           input order_e ord);
    logic [S_TDATA_W-1:0] word;
    word = '0;
    word[S_PARENT_LO +: IDX_W]  = parent;
    word[S_SIDE_LO]             = side;
    word[S_LABEL_LO +: LABEL_W] = label;
    word[S_ORDER_LO +: ORDER_W] = ord;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= func;
    do @(posedge clk_i); while (!s_tready);
    sb.note_item(func, parent, side, label, ord);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (sb.pending_visits.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [LABEL_W-1:0] rand_label();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    int unsigned parents [$];
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_item(func_e'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 63)),
                1'($urandom_range(0, 1)), rand_label(), order_e'($urandom_range(0, 3)));
    end else if (pick < 55) begin
      for (int unsigned k = 1; k <= 31; k++)
        if (sb.is_live(k)) parents.push_back(k);
      if (pick < 12 || parents.size() == 0)
        send_item(FUNC_ROOT, IDX_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                  rand_label(), order_e'($urandom_range(0, 3)));
      else
        send_item(FUNC_CHILD, IDX_W'(parents[$urandom_range(0, parents.size() - 1)]),
                  1'($urandom_range(0, 1)), rand_label(), order_e'($urandom_range(0, 3)));
    end else if (pick < 60) begin
      send_item(FUNC_CHILD, IDX_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                rand_label(), order_e'($urandom_range(0, 3)));
    end else if (pick < 95) begin
      send_item(FUNC_TRAV, IDX_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                rand_label(), order_e'($urandom_range(0, 2)));
    end else begin
      send_item(FUNC_TRAV, IDX_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                rand_label(), ORD_NONE);
    end
  endtask

  initial begin
    int unsigned sent;
    int burst;
    int gap;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(FUNC_TRAV, 6'd0, 1'b0, '0, ORD_PRE);
    send_item(FUNC_TRAV, 6'd63, 1'b1, '1, ORD_IN);
    send_item(FUNC_TRAV, 6'd5, 1'b0, '0, ORD_POST);
    send_item(FUNC_TRAV, 6'd0, 1'b0, '0, ORD_NONE);
    send_item(FUNC_CHILD, 6'd1, 1'b0, 64'hA5A5_0000_FFFF_5A5A, ORD_PRE);
    send_item(FUNC_TRAV, 6'd0, 1'b0, '0, ORD_PRE);
    send_item(FUNC_ROOT, 6'd63, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ORD_NONE);
    send_item(FUNC_CHILD, 6'd0, 1'b1, 64'h1111_2222_3333_4444, ORD_PRE);
    send_item(FUNC_CHILD, 6'd32, 1'b0, 64'h5555_6666_7777_8888, ORD_PRE);
    send_item(FUNC_CHILD, 6'd63, 1'b1, 64'h9999_AAAA_BBBB_CCCC, ORD_PRE);
    send_item(FUNC_CHILD, 6'd31, 1'b1, 64'h8000_0000_0000_0001, ORD_PRE);
    send_item(FUNC_CHILD, 6'd1, 1'b1, 64'h0, ORD_PRE);
    send_item(FUNC_CHILD, 6'd3, 1'b1, 64'h0123_4567_89AB_CDEF, ORD_PRE);
    send_item(FUNC_CHILD, 6'd7, 1'b0, 64'hFEDC_BA98_7654_3210, ORD_PRE);
    send_item(FUNC_TRAV, 6'd0, 1'b0, '0, ORD_PRE);
    send_item(FUNC_TRAV, 6'd0, 1'b0, '0, ORD_IN);
    send_item(FUNC_TRAV, 6'd0, 1'b0, '0, ORD_POST);
    send_item(FUNC_TRAV, 6'd0, 1'b0, '0, ORD_NONE);
    send_item(FUNC_NONE, 6'd1, 1'b0, 64'hDEAD_BEEF_0000_0001, ORD_PRE);
    send_item(FUNC_ROOT, 6'd0, 1'b0, 64'h0F0F_F0F0_3C3C_C3C3, ORD_PRE);
    send_item(FUNC_TRAV, 6'd0, 1'b0, '0, ORD_IN);
    drain_results();

    sent = 21;
    while (sent < ITEM_TOTAL) begin
      burst = $urandom_range(1, 12);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < burst && sent < ITEM_TOTAL; i++) begin
        send_random_item();
        sent++;
        if (sent == ITEM_TOTAL / 2) drain_results();
      end
      idle_cycles(gap);
    end

    drain_results();
    repeat (250) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_visits.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
